// ----- rtl/lrukv_pkg.sv -----
package lrukv_pkg;

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   localparam logic [VAL_W-1:0] MISS_VALUE = '1;
   localparam logic [VAL_W-1:0] PUT_VALUE  = '0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic             op;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } lrukv_req_type;

   typedef struct packed {
      logic             found;
      logic [VAL_W-1:0] read_value;
   } lrukv_rsp_type;

endpackage

// ----- rtl/lrukv_core.sv -----
module lrukv_core #(
   parameter int ENTRIES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  lrukv_pkg::lrukv_req_type      req,
   input  logic [lrukv_pkg::CAP_W-1:0]   capacity,
   output lrukv_pkg::lrukv_rsp_type      rsp
);
   import lrukv_pkg::*;

   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = ((CNT_W > CAP_W) ? CNT_W : CAP_W) + 1;

   logic [KEY_W-1:0]  key_ff  [ENTRIES];
   logic [VAL_W-1:0]  val_ff  [ENTRIES];
   logic [RANK_W-1:0] rank_ff [ENTRIES];
   logic [RANK_W-1:0] rank_in [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]   used_ff, used_in;

   logic [ENTRIES-1:0] hit_vec, victim_vec, free_vec, slot_vec, sel_vec, inc_vec;
   logic               hit_any, is_put, full, insert;
   logic [VAL_W-1:0]   hit_value;
   logic [RANK_W-1:0]  hit_rank;
   logic [RANK_W-1:0]  used_m1;
   logic [CAP_W-1:0]   cap_eff;

   always_comb begin
      hit_value = '0;
      hit_rank  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (key_ff[i] == req.key);
         hit_value  = hit_value | (hit_vec[i] ? val_ff[i] : '0);
         hit_rank   = hit_rank | (hit_vec[i] ? rank_ff[i] : '0);
      end
      hit_any = |hit_vec;
      is_put  = (req.op == OP_PUT);

      // capacity 0 acts as 1; above ENTRIES the fill reaching ENTRIES ends it
      cap_eff = (capacity == '0) ? CAP_W'(1) : capacity;
      full    = (CMP_W'(used_ff) >= CMP_W'(cap_eff)) || (used_ff == CNT_W'(ENTRIES));

      // valid ranks are distinct 0..used-1, so the LRU entry holds used-1
      used_m1 = RANK_W'(used_ff - CNT_W'(1));
      for (int i = 0; i < ENTRIES; i++)
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == used_m1);

      free_vec = ~valid_ff;
      slot_vec = free_vec & (~free_vec + ENTRIES'(1));

      priority if (hit_any) sel_vec = hit_vec;
      else if (!is_put)     sel_vec = '0;
      else if (full)        sel_vec = victim_vec;
      else                  sel_vec = slot_vec;

      insert = is_put && !hit_any;

      for (int i = 0; i < ENTRIES; i++) begin
         inc_vec[i] = valid_ff[i] && !sel_vec[i] &&
                      (hit_any ? (rank_ff[i] < hit_rank) : is_put);
         if (sel_vec[i])
            rank_in[i] = '0;
         else if (inc_vec[i])
            rank_in[i] = rank_ff[i] + RANK_W'(1);
         else
            rank_in[i] = rank_ff[i];
      end
      valid_in = insert ? (valid_ff | sel_vec) : valid_ff;
      used_in  = (insert && !full) ? used_ff + CNT_W'(1) : used_ff;

      rsp.found      = hit_any;
      rsp.read_value = is_put ? PUT_VALUE : (hit_any ? hit_value : MISS_VALUE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         used_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++)
            rank_ff[i] <= '0;
      end else if (step_en) begin
         valid_ff <= valid_in;
         used_ff  <= used_in;
         for (int i = 0; i < ENTRIES; i++)
            rank_ff[i] <= rank_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (sel_vec[i] && is_put)
               val_ff[i] <= req.value;
            if (sel_vec[i] && insert)
               key_ff[i] <= req.key;
         end
      end
   end

endmodule

// ----- rtl/lru_key_value_cache_unit.sv -----
// channel | dir | beat fields (low bit up)
// req     | in  | tuser: op; tdata: key[31:0], value[63:32]
// rsp     | out | tuser: found; tdata: read_value[31:0]
// csr     | in  | data: capacity[4:0]
//
// One item per cycle while responses are taken; both ports are registered.
// The rate is set by the combinational parallel key compare and LRU rank update.
// Synchronous active-high reset empties the cache and sets capacity to 16.
// A held response stalls the request side only while the input register is full.
module lru_key_value_cache_unit #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // key[31:0], value[63:32]
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[31:0]
   output logic        rsp_tuser,   // found
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // capacity[4:0]
);
   import lrukv_pkg::*;

   logic          in_valid_ff, in_valid_in;
   lrukv_req_type in_req_ff;
   logic          out_valid_ff, out_valid_in;
   lrukv_rsp_type out_rsp_ff, core_rsp;
   logic [CAP_W-1:0] cap_ff;
   logic          advance, req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (req_fire)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (advance)
         out_valid_in = 1'b1;
      else if (rsp_tready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cap_ff       <= CAPACITY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready)
            cap_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff.op    <= req_tuser;
         in_req_ff.key   <= req_tdata[31:0];
         in_req_ff.value <= req_tdata[63:32];
      end
      if (advance)
         out_rsp_ff <= core_rsp;
   end

   lrukv_core #(
      .ENTRIES (ENTRIES)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step_en  (advance),
      .req      (in_req_ff),
      .capacity (cap_ff),
      .rsp      (core_rsp)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_rsp_ff.read_value;
   assign rsp_tuser  = out_rsp_ff.found;

endmodule

// ----- rtl/lrukv_checker.sv -----
module lrukv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // a miss reports either the put marker or the get miss marker
   a_miss_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> (rsp_tdata == 32'h0) || (rsp_tdata == 32'hFFFF_FFFF))
      else $error("miss response with stray data");

   // request side backs up only behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without a held response");

   // no response right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind lru_key_value_cache_unit lrukv_checker u_lrukv_checker (.*);
